[rtl/multi_channel_countdown_timer_unit_defines.svh]
// ----------------------------------------------------------------------------
// Countdown timer unit assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_COUNTDOWN_TIMER_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_COUNTDOWN_TIMER_UNIT_DEFINES_SVH

// same-cycle implication
`define MCT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mct_pkg.sv]
// ----------------------------------------------------------------------------
// Countdown timer package
// Shared constants, command and register codes, and the result record.
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int unsigned Stations = 9;      // 6 .. 16
  localparam int unsigned SecondMs = 1000;   // 1 .. 65535
  localparam int unsigned ActBits  = 9;
  localparam int unsigned ActN     = (Stations < ActBits) ? Stations : ActBits;
  localparam int unsigned StaIdxW  = $clog2(Stations);
  localparam int unsigned TimeW    = 16;
  localparam int unsigned AccW     = 16;
  localparam int unsigned StepW    = 10;
  localparam int unsigned LayoutW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned BeepW    = 3;

  localparam logic [AccW-1:0]   SecondMsVal = AccW'(SecondMs);
  localparam logic [StepW-1:0]  StepReset   = StepW'(10);
  localparam logic [BeepW-1:0]  BeepsOnDone = BeepW'(5);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_TICK_STEP = 1'b0,
    REG_LAYOUT    = 1'b1
  } reg_idx_e;

  typedef enum logic [LayoutW-1:0] {
    LAYOUT_FOUR  = 2'd0,
    LAYOUT_SIX   = 2'd1,
    LAYOUT_NINE  = 2'd2,
    LAYOUT_SPARE = 2'd3
  } layout_e;

  typedef struct packed {
    logic                 running;
    logic [ActBits-1:0]   done_mask;
    logic [ActBits-1:0]   stop_mask;
    logic [BeepW-1:0]     beep_count;
    logic [TimeW-1:0]     remaining_time;
    logic                 second_fired;
  } res_t;

endpackage

[rtl/mct_core.sv]
// ----------------------------------------------------------------------------
// Countdown timer core
// Prescaler, run flag, per-station countdowns and presets; one transaction
// per accepted cycle, result computed in the same cycle the state updates.
// ----------------------------------------------------------------------------
module mct_core import mct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  reg_idx_e            cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  logic [1:0]          command_i,
  input  logic [3:0]          station_i,
  input  logic [TimeW-1:0]    time_value_i,
  input  logic [ActBits-1:0]  active_mask_i,
  output res_t                res_o
);

  logic [StepW-1:0]   step_q;
  layout_e            layout_q;
  logic [AccW-1:0]    acc_q, acc_d;
  logic               run_q, run_d;
  logic [ActN-1:0]    done_q, done_d;
  logic [TimeW-1:0]   rem_q    [Stations];
  logic [TimeW-1:0]   rem_d    [Stations];
  logic [TimeW-1:0]   preset_q [Stations];
  logic [TimeW-1:0]   preset_d [Stations];

  logic [ActN-1:0]    grp;
  logic               complete;
  logic [AccW-1:0]    acc_sum;
  logic               fire;
  logic [ActN-1:0]    stop_bits;
  logic               sta_ok;
  logic [StaIdxW-1:0] idx;
  cmd_e               cmd;

  assign cmd    = cmd_e'(command_i);
  assign sta_ok = ({1'b0, station_i} < 5'(Stations));
  assign idx    = station_i[StaIdxW-1:0];

  // group of stations whose completion ends a run
  always_comb begin
    unique case (layout_q)
      LAYOUT_FOUR: grp = ActN'(ActBits'(9'h033));
      LAYOUT_SIX:  grp = ActN'(ActBits'(9'h03F));
      default:     grp = ActN'(ActBits'(9'h1FF));
    endcase
  end

  assign complete = (grp != '0) && ((done_q & grp) == grp);
  assign acc_sum  = acc_q + AccW'(step_q);
  assign fire     = (acc_sum == SecondMsVal);

  always_comb begin
    acc_d     = acc_q;
    run_d     = run_q;
    done_d    = done_q;
    rem_d     = rem_q;
    preset_d  = preset_q;
    stop_bits = '0;
    unique case (cmd)
      CMD_TICK: begin
        if (complete) begin
          run_d  = 1'b0;
          done_d = '0;
          rem_d  = preset_q;
        end
        if (run_q && !complete) begin
          if (fire) begin
            acc_d = '0;
            for (int i = 0; i < ActN; i++) begin
              if (active_mask_i[i] && !done_q[i]) begin
                if (rem_q[i] != '0) begin
                  rem_d[i] = rem_q[i] - TimeW'(1);
                end else begin
                  stop_bits[i] = 1'b1;
                  done_d[i]    = 1'b1;
                end
              end
            end
          end else begin
            acc_d = acc_sum;
          end
        end else begin
          // stopped or group complete: drop flags and reload every countdown
          done_d = '0;
          rem_d  = preset_q;
        end
      end
      CMD_LOAD: begin
        if (sta_ok) begin
          preset_d[idx] = time_value_i;
        end
      end
      CMD_START: run_d = 1'b1;
      CMD_STOP:  run_d = 1'b0;
      default:   run_d = run_q;
    endcase
  end

  always_comb begin
    res_o.running        = run_d;
    res_o.done_mask      = ActBits'(done_d);
    res_o.stop_mask      = ActBits'(stop_bits);
    res_o.beep_count     = (cmd == CMD_TICK && complete) ? BeepsOnDone : '0;
    res_o.remaining_time = sta_ok ? rem_d[idx] : '0;
    res_o.second_fired   = (cmd == CMD_TICK) && run_q && !complete && fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= StepReset;
      layout_q <= LAYOUT_FOUR;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TICK_STEP: step_q   <= cfg_data_i[StepW-1:0];
        REG_LAYOUT:    layout_q <= layout_e'(cfg_data_i[LayoutW-1:0]);
        default:       step_q   <= step_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      run_q    <= 1'b0;
      done_q   <= '0;
      rem_q    <= '{default: '0};
      preset_q <= '{default: '0};
    end else if (accept_i) begin
      acc_q    <= acc_d;
      run_q    <= run_d;
      done_q   <= done_d;
      rem_q    <= rem_d;
      preset_q <= preset_d;
    end
  end

endmodule

[rtl/mct_obuf.sv]
// ----------------------------------------------------------------------------
// Countdown timer output buffer
// Two-entry result queue that keeps the input side moving while the
// consumer stalls, until both entries are full.
// ----------------------------------------------------------------------------
module mct_obuf import mct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_ready_i,
  output res_t res_o
);

  res_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && pop_ready_i;
  assign res_o   = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

[rtl/multi_channel_countdown_timer_unit.sv]
// ----------------------------------------------------------------------------
// Multi-channel countdown timer unit
// Nine station countdowns sharing one millisecond-to-second prescaler.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i/in_ready_o  | command, station, time_value, active_mask
//  out     | out_valid_o/out_ready_i| running, done_mask, stop_mask, beep_count,
//          |                        | remaining_time, second_fired
//  cfg     | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
// One transaction per cycle while in_ready_o is high; its result is queued.
// The result queue holds two entries; in_ready_o drops only when both are full.
// Reset clears prescaler, run flag, done flags, countdowns and presets at once.
// ----------------------------------------------------------------------------
`include "multi_channel_countdown_timer_unit_defines.svh"

module multi_channel_countdown_timer_unit import mct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [3:0]          station_i,
  input  logic [TimeW-1:0]    time_value_i,
  input  logic [ActBits-1:0]  active_mask_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                running_o,
  output logic [ActBits-1:0]  done_mask_o,
  output logic [ActBits-1:0]  stop_mask_o,
  output logic [BeepW-1:0]    beep_count_o,
  output logic [TimeW-1:0]    remaining_time_o,
  output logic                second_fired_o
);

  logic accept;
  res_t res_new, res_out;

  assign accept = in_valid_i && in_ready_o;

  mct_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (reg_idx_e'(cfg_index_i)),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .command_i     (command_i),
    .station_i     (station_i),
    .time_value_i  (time_value_i),
    .active_mask_i (active_mask_i),
    .res_o         (res_new)
  );

  mct_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res_new),
    .ready_o     (in_ready_o),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign running_o        = res_out.running;
  assign done_mask_o      = res_out.done_mask;
  assign stop_mask_o      = res_out.stop_mask;
  assign beep_count_o     = res_out.beep_count;
  assign remaining_time_o = res_out.remaining_time;
  assign second_fired_o   = res_out.second_fired;

  `MCT_ASSERT(a_beep_stops, out_valid_o && beep_count_o != '0, !running_o && beep_count_o == BeepsOnDone, "beep request without stop")
  `MCT_ASSERT(a_stop_in_done, out_valid_o, (stop_mask_o & ~done_mask_o) == '0, "stop bit outside done flags")
  `MCT_ASSERT(a_stop_on_fire, out_valid_o && stop_mask_o != '0, second_fired_o, "station stopped without a second")
  `MCT_ASSERT_NXT(a_accept_shows, accept, out_valid_o, "accepted transaction left no result")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Countdown timer unit testbench
// Drives commands through the valid/ready input channel and checks every
// result against a cycle-free model of the nine station countdowns, the shared
// prescaler and the group completion rule, across several register settings.
// ----------------------------------------------------------------------------
module tb import mct_pkg::*; ();

  class station_timer_model;
    logic [StepW-1:0]   step;
    layout_e            layout;
    logic [AccW-1:0]    acc;
    logic               run;
    logic [ActBits-1:0] done;
    logic [TimeW-1:0]   remain [Stations];
    logic [TimeW-1:0]   preset [Stations];
    res_t               pending_results [$];
    int unsigned        n_taken;
    int unsigned        n_checked;
    int unsigned        n_fires;
    int unsigned        n_groups;
    int unsigned        n_errors;

    function new();
      step      = StepReset;
      layout    = LAYOUT_FOUR;
      acc       = '0;
      run       = 1'b0;
      done      = '0;
      n_taken   = 0;
      n_checked = 0;
      n_fires   = 0;
      n_groups  = 0;
      n_errors  = 0;
      for (int i = 0; i < Stations; i++) begin
        remain[i] = '0;
        preset[i] = '0;
      end
    endfunction

    function void set_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
      if (idx == REG_TICK_STEP) begin
        step = val[StepW-1:0];
      end else begin
        layout = layout_e'(val[LayoutW-1:0]);
      end
    endfunction

    function void reload_all();
      done = '0;
      for (int i = 0; i < Stations; i++) remain[i] = preset[i];
    endfunction

    function void take_command(cmd_e cmd, logic [3:0] st, logic [TimeW-1:0] tv,
                               logic [ActBits-1:0] act);
      res_t               r;
      logic [ActBits-1:0] grp;
      r = '0;
      n_taken++;
      case (cmd)
        CMD_TICK: begin
          case (layout)
            LAYOUT_FOUR: grp = ActBits'(9'h033);
            LAYOUT_SIX:  grp = ActBits'(9'h03F);
            default:     grp = ActBits'(9'h1FF);
          endcase
          for (int i = ActN; i < ActBits; i++) grp[i] = 1'b0;
          // group check comes first, running or not
          if (grp != '0 && (done & grp) == grp) begin
            reload_all();
            r.beep_count = BeepsOnDone;
            run = 1'b0;
            n_groups++;
          end
          if (run) begin
            acc = acc + AccW'(step);
            if (acc == SecondMsVal) begin
              r.second_fired = 1'b1;
              n_fires++;
              for (int i = 0; i < ActN; i++) begin
                if (act[i] && !done[i]) begin
                  if (remain[i] != '0) begin
                    remain[i] = remain[i] - 1'b1;
                  end else begin
                    r.stop_mask[i] = 1'b1;
                    done[i] = 1'b1;
                  end
                end
              end
              acc = '0;
            end
          end else begin
            reload_all();
          end
        end
        CMD_LOAD: begin
          if (st < Stations) preset[st] = tv;
        end
        CMD_START: run = 1'b1;
        default:   run = 1'b0;
      endcase
      r.running        = run;
      r.done_mask      = done;
      r.remaining_time = (st < Stations) ? remain[st] : '0;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [TimeW-1:0] want,
                                logic [TimeW-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("result arrived with no transaction pending");
        n_errors++;
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      compare_field("running", TimeW'(want.running), TimeW'(got.running));
      compare_field("done_mask", TimeW'(want.done_mask), TimeW'(got.done_mask));
      compare_field("stop_mask", TimeW'(want.stop_mask), TimeW'(got.stop_mask));
      compare_field("beep_count", TimeW'(want.beep_count), TimeW'(got.beep_count));
      compare_field("remaining_time", want.remaining_time, got.remaining_time);
      compare_field("second_fired", TimeW'(want.second_fired), TimeW'(got.second_fired));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          command_i;
  logic [3:0]          station_i;
  logic [TimeW-1:0]    time_value_i;
  logic [ActBits-1:0]  active_mask_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                running_o;
  logic [ActBits-1:0]  done_mask_o;
  logic [ActBits-1:0]  stop_mask_o;
  logic [BeepW-1:0]    beep_count_o;
  logic [TimeW-1:0]    remaining_time_o;
  logic                second_fired_o;

  station_timer_model model;
  int unsigned        burst_left = 0;
  int unsigned        n_settings = 0;
  logic [15:0]        rx_cycle   = '0;

  multi_channel_countdown_timer_unit u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1000000;
    $display("[multi_channel_countdown_timer_unit] ERROR");
    $finish;
  end

  // receiver: rotate through always ready, random, one in four, one in eight
  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[8:7])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= 1'($urandom_range(0, 1));
      2'd2:    out_ready_i <= (rx_cycle[1:0] == 2'd0);
      default: out_ready_i <= (rx_cycle[2:0] == 3'd7);
    endcase
  end

  always @(posedge clk_i) begin : watch_results
    res_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.running        = running_o;
      seen.done_mask      = done_mask_o;
      seen.stop_mask      = stop_mask_o;
      seen.beep_count     = beep_count_o;
      seen.remaining_time = remaining_time_o;
      seen.second_fired   = second_fired_o;
      model.check_result(seen);
    end
  end

  function automatic logic [3:0] pick_station();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(Stations, 15))
                                       : 4'($urandom_range(0, Stations - 1));
  endfunction

  function automatic logic [TimeW-1:0] pick_time();
    return ($urandom_range(0, 7) == 0) ? TimeW'($urandom) : TimeW'($urandom_range(0, 3));
  endfunction

  function automatic logic [ActBits-1:0] pick_mask();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2, 3: return ActBits'($urandom);
      default: return '1;
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send(cmd_e cmd, logic [3:0] st, logic [TimeW-1:0] tv,
                      logic [ActBits-1:0] act);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    station_i     <= st;
    time_value_i  <= tv;
    active_mask_i <= act;
    do @(posedge clk_i); while (!in_ready_o);
    model.take_command(cmd, st, tv, act);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (model.pending_results.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  // bring the prescaler back to zero so the next step size lines up with a second;
  // past the second mark, step by a full second until the sum wraps
  task automatic settle_prescaler();
    logic [StepW-1:0] fix;
    while (model.acc != '0) begin
      fix = (model.acc > SecondMsVal) ? StepW'(SecondMs) : StepW'(SecondMsVal - model.acc);
      if (fix != model.step) begin
        wait_drained();
        write_reg(REG_TICK_STEP, CfgDataW'(fix));
      end
      send(CMD_START, pick_station(), pick_time(), pick_mask());
      send(CMD_TICK, pick_station(), pick_time(), pick_mask());
    end
  endtask

  task automatic set_phase(int unsigned step_ms, layout_e lay);
    settle_prescaler();
    wait_drained();
    write_reg(REG_TICK_STEP, CfgDataW'(step_ms));
    write_reg(REG_LAYOUT, CfgDataW'(lay));
    n_settings++;
  endtask

  // mostly well-formed runs: load presets, start, tick; with stray commands and noise
  task automatic run_sessions(int unsigned n);
    int unsigned stop_at;
    stop_at = model.n_taken + n;
    while (model.n_taken < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send(cmd_e'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), TimeW'($urandom),
             ActBits'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send(CMD_LOAD, pick_station(), pick_time(), pick_mask());
        end
        send(CMD_START, pick_station(), pick_time(), pick_mask());
        repeat ($urandom_range(3, 24)) begin
          case ($urandom_range(0, 15))
            0:       send(CMD_STOP, pick_station(), pick_time(), pick_mask());
            1:       send(CMD_LOAD, pick_station(), pick_time(), pick_mask());
            2:       send(CMD_START, pick_station(), pick_time(), pick_mask());
            default: send(CMD_TICK, pick_station(), pick_time(), pick_mask());
          endcase
        end
        if ($urandom_range(0, 3) == 0) begin
          send(CMD_STOP, pick_station(), pick_time(), pick_mask());
          send(CMD_TICK, pick_station(), pick_time(), pick_mask());
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_TICK_STEP;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = CMD_TICK;
    station_i     = '0;
    time_value_i  = '0;
    active_mask_i = '0;
    model = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset step size: a few ticks add up without reaching a second
    send(CMD_START, 4'd0, '0, '0);
    repeat (3) send(CMD_TICK, 4'd0, '0, '1);
    send(CMD_STOP, 4'd0, '0, '0);
    send(CMD_TICK, 4'd0, '0, '0);

    // one second per tick, four-station rule
    set_phase(SecondMs, LAYOUT_FOUR);
    send(CMD_LOAD, 4'd0, '1, '1);
    send(CMD_LOAD, 4'd15, TimeW'(16'hABCD), '0);
    send(CMD_TICK, 4'd0, '0, '0);
    send(CMD_START, 4'd8, '0, '0);
    send(CMD_TICK, 4'd0, '0, '1);
    send(CMD_LOAD, 4'd0, '0, '0);
    send(CMD_STOP, 4'd0, '0, '0);
    send(CMD_TICK, 4'd9, '0, '0);
    send(CMD_START, 4'd0, '0, '0);
    send(CMD_TICK, 4'd4, '0, '1);
    // group finished, then stopped: completion still fires on the next tick
    send(CMD_STOP, 4'd0, '0, '0);
    send(CMD_TICK, 4'd15, '0, '0);
    send(CMD_START, 4'd1, '0, '0);
    send(CMD_TICK, 4'd1, '0, '0);
    send(CMD_TICK, 4'd1, '0, '1);
    send(CMD_TICK, 4'd1, '0, '1);

    set_phase(SecondMs, LAYOUT_SIX);
    run_sessions(150);
    set_phase(500, LAYOUT_NINE);
    run_sessions(150);
    set_phase(250, LAYOUT_SPARE);
    run_sessions(150);
    // overshoot: the sum skips past a second; settling afterwards walks it through the wrap
    set_phase(600, LAYOUT_FOUR);
    run_sessions(40);
    set_phase(200, LAYOUT_FOUR);
    run_sessions(150);
    set_phase(1, LAYOUT_NINE);
    run_sessions(60);
    set_phase(125, LAYOUT_SIX);
    run_sessions(150);
    set_phase(SecondMs, LAYOUT_SPARE);
    run_sessions(200);

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("covered %0d transactions over %0d register settings, %0d results checked",
             model.n_taken, n_settings, model.n_checked);
    $display("saw %0d second pulses and %0d group completions",
             model.n_fires, model.n_groups);
    if (model.n_errors == 0) begin
      $display("[multi_channel_countdown_timer_unit] OK");
    end else begin
      $display("[multi_channel_countdown_timer_unit] ERROR");
    end
    $finish;
  end

endmodule
